// ===== src/mvlm_pkg.sv =====
// mvlm_pkg: types, constants and helper functions of the voltage limit monitor
// no dependencies; imported by the interfaces, the top level, mvlm_bcd and the bench
package mvlm_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int OP_W  = 4;
    localparam int CH_W  = 3;
    localparam int SMP_W = 16;
    localparam int MV_W  = 14;
    localparam int LIM_W = 13;
    localparam int DIG_W = 4;
    localparam int ACC_W = SMP_W + 14;

    localparam logic [LIM_W-1:0] LIMIT_MAX    = LIM_W'(4096);
    localparam logic [LIM_W-1:0] LIMIT_TOP10  = LIM_W'(4086);
    localparam logic [LIM_W-1:0] LIMIT_STEP10 = LIM_W'(10);

    typedef logic [CH_AW-1:0] t_addr;

    typedef enum logic [OP_W-1:0] {
        OP_STORE    = 4'd0,
        OP_SCAN     = 4'd1,
        OP_SELECTED = 4'd2,
        OP_NEXT     = 4'd3,
        OP_PREV     = 4'd4,
        OP_INC10    = 4'd5,
        OP_DEC10    = 4'd6,
        OP_INC1     = 4'd7,
        OP_DEC1     = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SPLIT,
        S_HOLD
    } t_state;

    // request and response of the decimal digit unit
    typedef struct packed {
        logic            start;
        logic [MV_W-1:0] value;
    } t_bcd_req;

    typedef struct packed {
        logic             done;
        logic [DIG_W-1:0] thou;
        logic [DIG_W-1:0] hund;
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] ones;
    } t_bcd_rsp;

    localparam int BCD_STEPS = 3;
    localparam int BCD_SW    = $clog2(BCD_STEPS);
    localparam logic [MV_W-1:0] BCD_UNITS [BCD_STEPS] = '{
        MV_W'(1000), MV_W'(100), MV_W'(10)
    };

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic [MV_W-1:0]  rem;
    } t_dig_step;

    // floor(raw * 8192 / 65535): x / 65535 == (x + (x >> 16) + 1) >> 16 for x below 2^32 - 1
    function automatic logic [MV_W-1:0] to_mv(input logic [SMP_W-1:0] raw);
        logic [ACC_W-1:0] acc;
        acc = {1'b0, raw, 13'b0} + ACC_W'(raw[SMP_W-1:3]) + ACC_W'(1);
        return acc[ACC_W-1:16];
    endfunction

    // one decimal digit of rem for the given unit, rem below ten units
    function automatic t_dig_step digit_step(input logic [MV_W-1:0] rem,
                                             input logic [MV_W-1:0] unit);
        t_dig_step r;
        r.digit = '0;
        for (int k = 1; k <= 9; k++) begin
            if ((MV_W+4)'(rem) >= (MV_W+4)'(k) * (MV_W+4)'(unit)) begin
                r.digit = DIG_W'(k);
            end
        end
        r.rem = MV_W'((MV_W+4)'(rem) - (MV_W+4)'(r.digit) * (MV_W+4)'(unit));
        return r;
    endfunction

endpackage

// ===== src/mvlm_in_if.sv =====
// mvlm_in_if: valid/ready channel that carries one operation item
// depends on mvlm_pkg for field widths
interface mvlm_in_if import mvlm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;

    modport source (output valid, op, channel, sample, input ready);
    modport sink   (input valid, op, channel, sample, output ready);
endinterface

// ===== src/mvlm_out_if.sv =====
// mvlm_out_if: valid/ready channel that carries one report item
// depends on mvlm_pkg for field widths
interface mvlm_out_if import mvlm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel_shown;
    logic [MV_W-1:0]  value_mv;
    logic [DIG_W-1:0] digit_thousands;
    logic [DIG_W-1:0] digit_hundreds;
    logic [DIG_W-1:0] digit_tens;
    logic [DIG_W-1:0] digit_ones;
    logic             over_limit;
    logic             is_limit_report;

    modport source (output valid, channel_shown, value_mv, digit_thousands, digit_hundreds,
                    digit_tens, digit_ones, over_limit, is_limit_report, input ready);
    modport sink   (input valid, channel_shown, value_mv, digit_thousands, digit_hundreds,
                    digit_tens, digit_ones, over_limit, is_limit_report, output ready);
endinterface

// ===== src/multichannel_voltage_limit_monitor.sv =====
// multichannel_voltage_limit_monitor: top level of the eight-channel voltage limit monitor
// depends on mvlm_pkg, mvlm_in_if, mvlm_out_if, mvlm_ram and mvlm_bcd
//
// usage
//   i_in carries one operation item (op, channel, sample); o_out returns exactly one
//   report item for every operation, in order
//   samples live in one memory, limits with their armed flag in a second memory;
//   both are read in the accept cycle and written back in the cycle after it
//   an item is not taken before the last one's report is done; the pace is set by the
//   read/modify/write of the memories, the digit unit, which produces one decimal digit
//   per cycle, the load of the output register and the idle cycle in which the next
//   item is taken
//   a finished report sits in the output register, so the next item is taken while
//   it waits; if the receiver still stalls when the following report is done, the
//   block holds that report and takes no new item until the output register frees up
//   reset clears the selection, the output valid and the per-entry valid bits;
//   an entry not written since reset reads as zero, so no clearing pass is needed
//   and the block is ready right after reset
module multichannel_voltage_limit_monitor import mvlm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvlm_in_if.sink    i_in,
    mvlm_out_if.source o_out
);

    typedef struct packed {
        logic [CH_W-1:0] shown;
        logic [MV_W-1:0] value;
        logic            over;
        logic            is_lim;
    } t_res;

    typedef struct packed {
        logic [CH_W-1:0]  channel_shown;
        logic [MV_W-1:0]  value_mv;
        logic [DIG_W-1:0] digit_thousands;
        logic [DIG_W-1:0] digit_hundreds;
        logic [DIG_W-1:0] digit_tens;
        logic [DIG_W-1:0] digit_ones;
        logic             over_limit;
        logic             is_limit_report;
    } t_out_item;

    // fsm
    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   exec;
    logic   out_load;
    logic   out_free;

    // captured item
    logic [OP_W-1:0]  r_op;
    logic [CH_W-1:0]  r_ch;
    logic [SMP_W-1:0] r_sample;
    t_addr            r_addr;
    logic             r_in_rng;

    // state outside the memories
    t_addr             r_sel;
    t_addr             n_sel;
    logic [CHANNELS-1:0] r_smp_vld;
    logic [CHANNELS-1:0] r_lim_vld;

    // memory ports
    t_addr            smp_raddr;
    logic [SMP_W-1:0] smp_q;
    logic [LIM_W:0]   lim_q;
    logic             smp_we;
    logic             lim_we;

    // execute stage
    t_op              op_e;
    logic [SMP_W-1:0] cur_smp;
    logic [LIM_W:0]   cur_lim_word;
    logic [LIM_W-1:0] cur_lim;
    logic             cur_armed;
    logic [MV_W-1:0]  mv;
    logic [LIM_W-1:0] n_lim;
    logic             lim_wr;
    t_res             n_res;
    t_res             r_res;

    // digits and output
    t_bcd_req  bcd_req;
    t_bcd_rsp  bcd_rsp;
    t_out_item r_out;
    logic      r_out_valid;

    logic in_acc;
    logic in_rng;
    t_op  in_op;

    assign in_acc = i_in.valid & in_ready;
    assign in_op  = t_op'(i_in.op);
    assign in_rng = (32'(i_in.channel) < CHANNELS);

    // store and scan address the named channel, everything else the selection
    always_comb begin
        case (in_op)
            OP_STORE, OP_SCAN: smp_raddr = t_addr'(i_in.channel);
            default:           smp_raddr = r_sel;
        endcase
    end

    mvlm_ram #(.WIDTH(SMP_W), .DEPTH(CHANNELS)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (r_addr),
        .i_wdata (r_sample),
        .i_raddr (smp_raddr),
        .o_rdata (smp_q)
    );

    // limit word: armed flag on top of the 13-bit limit
    mvlm_ram #(.WIDTH(LIM_W + 1), .DEPTH(CHANNELS)) u_lim_ram (
        .i_clk   (i_clk),
        .i_we    (lim_we),
        .i_waddr (r_sel),
        .i_wdata ({1'b1, n_lim}),
        .i_raddr (r_sel),
        .o_rdata (lim_q)
    );

    // ---------------- fsm ----------------
    assign out_free = ~r_out_valid | o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (bcd_rsp.done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        exec     = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_EXEC:  exec     = 1'b1;
            S_SPLIT: out_load = bcd_rsp.done & out_free;
            S_HOLD:  out_load = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    // ---------------- execute: read data in, write back and result out ----------------
    assign op_e         = t_op'(r_op);
    assign cur_smp      = (r_in_rng && r_smp_vld[r_addr]) ? smp_q : '0;
    assign cur_lim_word = r_lim_vld[r_sel] ? lim_q : '0;
    assign cur_lim      = cur_lim_word[LIM_W-1:0];
    assign cur_armed    = cur_lim_word[LIM_W];
    assign mv           = to_mv(cur_smp);

    always_comb begin
        n_sel        = r_sel;
        n_lim        = cur_lim;
        lim_wr       = 1'b0;
        n_res.shown  = CH_W'(r_sel);
        n_res.value  = '0;
        n_res.over   = 1'b0;
        n_res.is_lim = 1'b0;
        case (op_e)
            OP_STORE: begin
                n_res.shown = r_ch;
            end
            OP_SCAN: begin
                n_res.shown = r_ch;
                n_res.value = mv;
            end
            OP_SELECTED: begin
                n_res.value = mv;
                n_res.over  = cur_armed & (mv > MV_W'(cur_lim));
            end
            OP_NEXT: begin
                n_sel       = (r_sel == t_addr'(CHANNELS - 1)) ? '0 : r_sel + 1'b1;
                n_res.shown = CH_W'(n_sel);
            end
            OP_PREV: begin
                n_sel       = (r_sel == '0) ? t_addr'(CHANNELS - 1) : r_sel - 1'b1;
                n_res.shown = CH_W'(n_sel);
            end
            OP_INC10, OP_DEC10, OP_INC1, OP_DEC1: begin
                case (op_e)
                    OP_INC10: n_lim = (cur_lim > LIMIT_TOP10) ? LIMIT_MAX
                                                              : cur_lim + LIMIT_STEP10;
                    OP_DEC10: n_lim = (cur_lim < LIMIT_STEP10) ? '0
                                                               : cur_lim - LIMIT_STEP10;
                    OP_INC1:  n_lim = (cur_lim >= LIMIT_MAX) ? LIMIT_MAX : cur_lim + 1'b1;
                    default:  n_lim = (cur_lim == '0) ? '0 : cur_lim - 1'b1;
                endcase
                lim_wr       = 1'b1;
                n_res.value  = MV_W'(n_lim);
                n_res.is_lim = 1'b1;
            end
            default: begin
                n_res.shown = CH_W'(r_sel);
            end
        endcase
    end

    assign smp_we = exec & (op_e == OP_STORE) & r_in_rng;
    assign lim_we = exec & lim_wr;

    // digit split starts on the value computed in the execute cycle
    assign bcd_req.start = exec;
    assign bcd_req.value = n_res.value;

    mvlm_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bcd_req),
        .o_rsp   (bcd_rsp)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= '0;
            r_smp_vld   <= '0;
            r_lim_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_sel <= n_sel;
            end
            if (smp_we) begin
                r_smp_vld[r_addr] <= 1'b1;
            end
            if (lim_we) begin
                r_lim_vld[r_sel] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_in.op;
            r_ch     <= i_in.channel;
            r_sample <= i_in.sample;
            r_addr   <= smp_raddr;
            case (in_op)
                OP_STORE, OP_SCAN: r_in_rng <= in_rng;
                default:           r_in_rng <= 1'b1;
            endcase
        end
        if (exec) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out.channel_shown   <= r_res.shown;
            r_out.value_mv        <= r_res.value;
            r_out.digit_thousands <= bcd_rsp.thou;
            r_out.digit_hundreds  <= bcd_rsp.hund;
            r_out.digit_tens      <= bcd_rsp.tens;
            r_out.digit_ones      <= bcd_rsp.ones;
            r_out.over_limit      <= r_res.over;
            r_out.is_limit_report <= r_res.is_lim;
        end
    end

    // ---------------- ports ----------------
    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.channel_shown   = r_out.channel_shown;
    assign o_out.value_mv        = r_out.value_mv;
    assign o_out.digit_thousands = r_out.digit_thousands;
    assign o_out.digit_hundreds  = r_out.digit_hundreds;
    assign o_out.digit_tens      = r_out.digit_tens;
    assign o_out.digit_ones      = r_out.digit_ones;
    assign o_out.over_limit      = r_out.over_limit;
    assign o_out.is_limit_report = r_out.is_limit_report;

endmodule

// ===== src/mvlm_ram.sv =====
// mvlm_ram: generic single-write, single-read memory with registered read data
// no dependencies
module mvlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/mvlm_bcd.sv =====
// mvlm_bcd: splits a millivolt value into four decimal digits, one digit per cycle
// depends on mvlm_pkg (t_bcd_req, t_bcd_rsp, digit_step)
module mvlm_bcd import mvlm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bcd_req i_req,
    output t_bcd_rsp o_rsp
);
    logic              r_busy;
    logic              r_done;
    logic [BCD_SW-1:0] r_step;
    logic [MV_W-1:0]   r_rem;
    logic [DIG_W-1:0]  r_dig [BCD_STEPS];
    t_dig_step         n_dig;
    logic              last_step;

    assign n_dig     = digit_step(r_rem, BCD_UNITS[r_step]);
    assign last_step = (r_step == BCD_SW'(BCD_STEPS - 1));

    // control, step index stays on the last unit once done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // remainder and digits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.value;
        end else if (r_busy) begin
            r_rem         <= n_dig.rem;
            r_dig[r_step] <= n_dig.digit;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.thou = r_dig[0];
    assign o_rsp.hund = r_dig[1];
    assign o_rsp.tens = r_dig[2];
    assign o_rsp.ones = r_rem[DIG_W-1:0];
endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the multichannel voltage limit monitor
// depends on mvlm_pkg, mvlm_in_if, mvlm_out_if and multichannel_voltage_limit_monitor
// an in-bench model of the channel stores predicts each report, checked in arrival order
module tb_top import mvlm_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 5;
    localparam int MAX_GAP       = 4;
    localparam int IDLE_LIMIT    = 500;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTS    = 40;
    localparam int RANDOM_ITEMS  = 960;

    localparam int FULL_SCALE_MV = 8192;
    localparam int RAW_FULL      = 65535;
    localparam int LIMIT_CEIL    = 4096;
    localparam int STEP_COARSE   = 10;
    localparam int STEP_FINE     = 1;

    // op codes the block does not define, answered with a plain selection report
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [CH_W-1:0]  chan;
        logic [MV_W-1:0]  mv;
        logic [DIG_W-1:0] thou;
        logic [DIG_W-1:0] hund;
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] ones;
        logic             over;
        logic             lim_rep;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    mvlm_in_if  in_ch ();
    mvlm_out_if out_ch ();

    multichannel_voltage_limit_monitor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // model of the channel stores and selection
    logic [SMP_W-1:0] model_sample [CHANNELS];
    logic [LIM_W-1:0] model_limit  [CHANNELS];
    logic             model_armed  [CHANNELS];
    logic [CH_AW-1:0] model_sel;
    t_report          report_q [$];

    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int error_count  = 0;
    int items_sent   = 0;
    int reports_seen = 0;
    int over_hits    = 0;
    int ceiling_hits = 0;
    int floor_hits   = 0;
    int idle_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one line per mismatch, printing stops after a while but counting goes on
    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic t_report make_report(int chan, int value, bit over, bit lim_rep);
        t_report r;
        r.chan    = CH_W'(chan);
        r.mv      = MV_W'(value);
        r.thou    = DIG_W'(value / 1000);
        r.hund    = DIG_W'((value / 100) % 10);
        r.tens    = DIG_W'((value / 10) % 10);
        r.ones    = DIG_W'(value % 10);
        r.over    = over;
        r.lim_rep = lim_rep;
        return r;
    endfunction

    // exact integer scaling of a raw code to millivolts
    function automatic int reading_of(logic [SMP_W-1:0] raw);
        return int'((longint'(raw) * FULL_SCALE_MV) / RAW_FULL);
    endfunction

    // update the model for one accepted operation and return the report it causes
    function automatic t_report apply_op(logic [OP_W-1:0] op, logic [CH_W-1:0] chan,
                                         logic [SMP_W-1:0] raw);
        int  sel;
        int  lim;
        int  v;
        bit  over;
        sel = int'(model_sel);
        case (op)
            OP_STORE: begin
                if (int'(chan) < CHANNELS) begin
                    model_sample[chan] = raw;
                end
                return make_report(chan, 0, 1'b0, 1'b0);
            end
            OP_SCAN: begin
                v = (int'(chan) < CHANNELS) ? reading_of(model_sample[chan]) : 0;
                return make_report(chan, v, 1'b0, 1'b0);
            end
            OP_SELECTED: begin
                v    = reading_of(model_sample[sel]);
                over = model_armed[sel] && (v > int'(model_limit[sel]));
                if (over) begin
                    over_hits++;
                end
                return make_report(sel, v, over, 1'b0);
            end
            OP_NEXT: begin
                model_sel = CH_AW'((sel >= CHANNELS - 1) ? 0 : sel + 1);
                return make_report(model_sel, 0, 1'b0, 1'b0);
            end
            OP_PREV: begin
                model_sel = CH_AW'((sel == 0) ? CHANNELS - 1 : sel - 1);
                return make_report(model_sel, 0, 1'b0, 1'b0);
            end
            OP_INC10, OP_DEC10, OP_INC1, OP_DEC1: begin
                lim = int'(model_limit[sel]);
                case (op)
                    OP_INC10: lim = (lim > LIMIT_CEIL - STEP_COARSE) ? LIMIT_CEIL
                                                                     : lim + STEP_COARSE;
                    OP_DEC10: lim = (lim < STEP_COARSE) ? 0 : lim - STEP_COARSE;
                    OP_INC1:  lim = (lim >= LIMIT_CEIL) ? LIMIT_CEIL : lim + STEP_FINE;
                    default:  lim = (lim == 0) ? 0 : lim - STEP_FINE;
                endcase
                if (lim == LIMIT_CEIL) begin
                    ceiling_hits++;
                end
                if (lim == 0) begin
                    floor_hits++;
                end
                model_limit[sel] = LIM_W'(lim);
                model_armed[sel] = 1'b1;
                return make_report(sel, lim, 1'b0, 1'b1);
            end
            default: begin
                return make_report(sel, 0, 1'b0, 1'b0);
            end
        endcase
    endfunction

    // present one item after a random gap, hold it until taken, then predict its report
    task automatic send_item(logic [OP_W-1:0] op, logic [CH_W-1:0] chan,
                             logic [SMP_W-1:0] raw);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.channel <= chan;
        in_ch.sample  <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        report_q.push_back(apply_op(op, chan, raw));
        items_sent++;
    endtask

    // raw code with a bias toward the ends of the converter range
    function automatic logic [SMP_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SMP_W'(1);
            3:       return SMP_W'(RAW_FULL - 1);
            default: return SMP_W'($urandom_range(0, RAW_FULL));
        endcase
    endfunction

    // op with a random channel and sample; for ops other than store and scan they are don't-care noise
    task automatic send_op(logic [OP_W-1:0] op);
        send_item(op, CH_W'($urandom_range(0, CHANNELS - 1)), draw_sample());
    endtask

    // store a sample on the selected channel whose reading sits at limit + delta,
    // then ask for the selected report to exercise the strict greater-than compare
    task automatic probe_threshold(int delta);
        int target;
        int raw;
        target = int'(model_limit[model_sel]) + delta;
        if (target < 0) begin
            target = 0;
        end
        raw = (target * RAW_FULL + FULL_SCALE_MV - 1) / FULL_SCALE_MV;
        if (raw > RAW_FULL) begin
            raw = RAW_FULL;
        end
        send_item(OP_STORE, CH_W'(model_sel), SMP_W'(raw));
        send_op(OP_SELECTED);
    endtask

    // full-scale, near-full-scale, one and mid codes on channels 0, 7, 3 and 5, each read back by a scan
    task automatic test_store_and_scan();
        send_item(OP_STORE, CH_W'(0), '1);
        send_op(OP_SCAN);
        send_item(OP_SCAN, CH_W'(0), draw_sample());
        send_item(OP_STORE, CH_W'(7), SMP_W'(RAW_FULL - 1));
        send_item(OP_SCAN, CH_W'(7), '0);
        send_item(OP_STORE, CH_W'(3), SMP_W'(1));
        send_item(OP_SCAN, CH_W'(3), '1);
        send_item(OP_STORE, CH_W'(5), SMP_W'(16'h8000));
        send_item(OP_SCAN, CH_W'(5), SMP_W'(16'h7fff));
    endtask

    // selection wraps below zero and above the top channel
    task automatic test_selection_wrap();
        send_op(OP_PREV);
        send_op(OP_SELECTED);
        send_op(OP_NEXT);
        send_op(OP_NEXT);
        send_op(OP_PREV);
    endtask

    // limit stays pinned at zero going down, and arming makes the report flag over
    task automatic test_limit_floor();
        send_op(OP_DEC1);
        send_op(OP_DEC10);
        send_op(OP_INC1);
        send_op(OP_INC10);
        send_op(OP_DEC10);
        send_op(OP_SELECTED);
        send_op(OP_DEC10);
    endtask

    task automatic test_unused_ops();
        send_op(OP_UNUSED_LO);
        send_op(OP_UNUSED_HI);
    endtask

    // climb one channel's limit to the ceiling, then poke around it
    task automatic test_limit_ceiling();
        int hops;
        hops = $urandom_range(1, CHANNELS - 1);
        repeat (hops) send_op(OP_NEXT);
        while (int'(model_limit[model_sel]) <= LIMIT_CEIL - STEP_COARSE) begin
            send_op(($urandom_range(0, 9) == 0) ? OP_INC1 : OP_INC10);
        end
        send_op(OP_INC10);
        send_op(OP_INC1);
        send_op(OP_DEC1);
        send_op(OP_INC10);
        send_op(OP_INC1);
        probe_threshold(0);
        probe_threshold(1);
        probe_threshold(-1);
    endtask

    // weighted mix: stores, reports, selection moves, adjust bursts, threshold probes, unused codes
    task automatic test_random_mix(int count);
        int start;
        int kind;
        int burst;
        logic [OP_W-1:0] adj;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 63) == 0) begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 28) begin
                send_op(OP_STORE);
            end else if (kind < 40) begin
                send_op(OP_SCAN);
            end else if (kind < 53) begin
                send_op(OP_SELECTED);
            end else if (kind < 63) begin
                send_op(($urandom_range(0, 1) == 0) ? OP_NEXT : OP_PREV);
            end else if (kind < 83) begin
                burst = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       adj = OP_INC10;
                    1:       adj = OP_DEC10;
                    2:       adj = OP_INC1;
                    default: adj = OP_DEC1;
                endcase
                repeat (burst) send_op(adj);
                send_op(OP_SELECTED);
            end else if (kind < 95) begin
                probe_threshold($urandom_range(0, 2) - 1);
            end else begin
                send_op(OP_LAST_UNUSED_PICK());
            end
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    function automatic logic [OP_W-1:0] OP_LAST_UNUSED_PICK();
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            flag_error($sformatf("report %0d %s got %0d expected %0d",
                                 reports_seen, name, got, want));
        end
    endtask

    // receiver: random stall per item, then compare against the oldest prediction
    initial begin : report_checker
        int      stall;
        t_report got;
        t_report want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            got = {out_ch.channel_shown, out_ch.value_mv, out_ch.digit_thousands,
                   out_ch.digit_hundreds, out_ch.digit_tens, out_ch.digit_ones,
                   out_ch.over_limit, out_ch.is_limit_report};
            if (report_q.size() == 0) begin
                flag_error($sformatf("report %0d arrived with nothing pending", reports_seen));
            end else begin
                want = report_q.pop_front();
                check_field("channel_shown", got.chan, want.chan);
                check_field("value_mv", got.mv, want.mv);
                check_field("digit_thousands", got.thou, want.thou);
                check_field("digit_hundreds", got.hund, want.hund);
                check_field("digit_tens", got.tens, want.tens);
                check_field("digit_ones", got.ones, want.ones);
                check_field("over_limit", got.over, want.over);
                check_field("is_limit_report", got.lim_rep, want.lim_rep);
            end
            reports_seen++;
        end
    end

    // watchdog: a long run of cycles with no handshake on either side means a hang
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        foreach (model_sample[i]) begin
            model_sample[i] = '0;
            model_limit[i]  = '0;
            model_armed[i]  = 1'b0;
        end
        model_sel = '0;

        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_STORE;
        in_ch.channel <= '0;
        in_ch.sample  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_store_and_scan();
        test_selection_wrap();
        test_limit_floor();
        test_unused_ops();
        test_limit_ceiling();
        test_random_mix(RANDOM_ITEMS);

        in_ch.valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d operations and %0d reports, %0d mismatches", items_sent,
                 reports_seen, error_count);
        $display("over-limit flagged %0d times, limit at ceiling %0d and at floor %0d times",
                 over_hits, ceiling_hits, floor_hits);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
